@@ rtl/atsr_pkg.sv @@
package atsr_pkg;

   // Input transaction: one tick or command from the host side
   typedef struct packed {
      logic [1:0]  action;
      logic [11:0] sample;
      logic        sample_ok;
   } req_type;

   // Result transaction: one byte of the report packet
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } rsp_type;

   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_RESET = 2'd1;
   localparam logic [1:0] ACT_OK    = 2'd2;

   localparam int          ELAPSED_BITS  = 17;
   localparam int          TIMEOUT_BITS  = 16;
   localparam logic [16:0] ELAPSED_MAX   = 17'h1FFFF;
   localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

   // Byte counter covers the five header bytes and up to five digits
   localparam int         IDX_BITS  = 3;
   localparam logic [2:0] HEAD_LAST = 3'd4;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_HASH = 8'h23;

   // Output byte source
   localparam logic [1:0] SEL_HEAD  = 2'd0;
   localparam logic [1:0] SEL_DIGIT = 2'd1;
   localparam logic [1:0] SEL_TAIL  = 2'd2;

   typedef struct packed {
      logic       latch;      // idle reset command: take sample, start conversion
      logic       count;      // waiting, non-OK item: advance and check elapsed time
      logic       conv_step;  // one double-dabble step
      logic       idx_clear;
      logic       idx_inc;
      logic       idx_load_top;
      logic       idx_dec;
      logic       load_out;
      logic [1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic timeout_hit;
      logic conv_last;
      logic head_last;
      logic digit_last;
      logic out_free;
   } status_type;

   function automatic logic [7:0] head_byte(input logic [IDX_BITS-1:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h21;  // '!'
         3'd1:    b = 8'h41;  // 'A'
         3'd2:    b = 8'h44;  // 'D'
         3'd3:    b = 8'h43;  // 'C'
         default: b = 8'h3D;  // '='
      endcase
      return b;
   endfunction

endpackage

@@ rtl/atsr_datapath.sv @@
module atsr_datapath #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  atsr_pkg::req_type           req_data,
   input  logic                        csr_wr_en,
   input  logic [15:0]                 csr_wr_data,
   input  atsr_pkg::cmd_type           cmd,
   output atsr_pkg::status_type        status,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output atsr_pkg::rsp_type           rsp_data
);
   import atsr_pkg::*;

   localparam int NUM_DIGITS = (SAMPLE_BITS <= 3) ? 1 :
                               (SAMPLE_BITS <= 6) ? 2 :
                               (SAMPLE_BITS <= 9) ? 3 :
                               (SAMPLE_BITS <= 13) ? 4 : 5;
   localparam int DIG_BITS = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int CNT_BITS = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;

   logic [TIMEOUT_BITS-1:0] timeout_ff, timeout_in;
   logic [ELAPSED_BITS-1:0] elapsed_ff, elapsed_in;
   logic [SAMPLE_BITS-1:0]  held_ff, held_in;
   logic [SAMPLE_BITS-1:0]  bin_ff, bin_in;
   logic [3:0]              digit_ff [NUM_DIGITS];
   logic [3:0]              digit_in [NUM_DIGITS];
   logic [CNT_BITS-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [IDX_BITS-1:0]     idx_ff, idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [SAMPLE_BITS-1:0]  sample_cut;
   logic [ELAPSED_BITS-1:0] elapsed_next;
   logic                    hit;
   logic [3:0]              adj [NUM_DIGITS];
   logic [IDX_BITS-1:0]     top_idx;
   logic [3:0]              cur_digit;

   assign sample_cut   = SAMPLE_BITS'(req_data.sample);
   assign elapsed_next = (req_data.action == ACT_TICK && elapsed_ff != ELAPSED_MAX) ?
                         elapsed_ff + 1'b1 : elapsed_ff;
   assign hit          = elapsed_next > {1'b0, timeout_ff};
   assign cur_digit    = digit_ff[idx_ff[DIG_BITS-1:0]];

   // Most significant nonzero digit, or the lowest digit for zero
   always_comb begin
      top_idx = '0;
      for (int d = 1; d < NUM_DIGITS; d++) begin
         if (digit_ff[d] != 4'd0) begin
            top_idx = IDX_BITS'(d);
         end
      end
   end

   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         adj[d] = (digit_ff[d] >= 4'd5) ? digit_ff[d] + 4'd3 : digit_ff[d];
      end
   end

   always_comb begin
      timeout_in   = csr_wr_en ? csr_wr_data : timeout_ff;
      elapsed_in   = elapsed_ff;
      held_in      = held_ff;
      bin_in       = bin_ff;
      digit_in     = digit_ff;
      bit_cnt_in   = bit_cnt_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      if (cmd.latch) begin
         held_in    = req_data.sample_ok ? sample_cut : held_ff;
         bin_in     = req_data.sample_ok ? sample_cut : held_ff;
         elapsed_in = '0;
         bit_cnt_in = '0;
         for (int d = 0; d < NUM_DIGITS; d++) begin
            digit_in[d] = 4'd0;
         end
      end
      if (cmd.count) begin
         elapsed_in = hit ? '0 : elapsed_next;
      end
      if (cmd.conv_step) begin
         // shift one binary bit into the BCD digits after the add-3 correction
         digit_in[0] = {adj[0][2:0], bin_ff[SAMPLE_BITS-1]};
         for (int d = 1; d < NUM_DIGITS; d++) begin
            digit_in[d] = {adj[d][2:0], adj[d-1][3]};
         end
         bin_in     = bin_ff << 1;
         bit_cnt_in = bit_cnt_ff + 1'b1;
      end

      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_load_top) begin
         idx_in = top_idx;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - 1'b1;
      end

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         case (cmd.sel)
            SEL_HEAD: begin
               rsp_in.tx_byte   = head_byte(idx_ff);
               rsp_in.last_byte = 1'b0;
            end
            SEL_DIGIT: begin
               rsp_in.tx_byte   = CHAR_ZERO | {4'd0, cur_digit};
               rsp_in.last_byte = 1'b0;
            end
            default: begin
               rsp_in.tx_byte   = CHAR_HASH;
               rsp_in.last_byte = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         elapsed_ff   <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         timeout_ff   <= timeout_in;
         elapsed_ff   <= elapsed_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      digit_ff   <= digit_in;
      bit_cnt_ff <= bit_cnt_in;
      idx_ff     <= idx_in;
      rsp_ff     <= rsp_in;
   end

   assign status.timeout_hit = hit;
   assign status.conv_last   = bit_cnt_ff == CNT_BITS'(SAMPLE_BITS - 1);
   assign status.head_last   = idx_ff == HEAD_LAST;
   assign status.digit_last  = idx_ff == '0;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/atsr_ctrl.sv @@
module atsr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_action,
   output logic                 req_stall,
   input  atsr_pkg::status_type status,
   output atsr_pkg::cmd_type    cmd
);
   import atsr_pkg::*;

   localparam logic [2:0] ST_READY = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_HEAD  = 3'd2;
   localparam logic [2:0] ST_DIGIT = 3'd3;
   localparam logic [2:0] ST_TAIL  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       waiting_ff, waiting_in;

   always_comb begin
      state_in   = state_ff;
      waiting_in = waiting_ff;
      cmd        = '0;
      cmd.sel    = SEL_HEAD;

      case (state_ff)
         ST_READY: begin
            if (req_valid) begin
               if (!waiting_ff) begin
                  if (req_action == ACT_RESET) begin
                     cmd.latch  = 1'b1;
                     waiting_in = 1'b1;
                     state_in   = ST_CONV;
                  end
               end else if (req_action == ACT_OK) begin
                  waiting_in = 1'b0;
               end else begin
                  cmd.count = 1'b1;
                  if (status.timeout_hit) begin
                     cmd.idx_clear = 1'b1;
                     state_in      = ST_HEAD;
                  end
               end
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (status.conv_last) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.sel      = SEL_HEAD;
               if (status.head_last) begin
                  cmd.idx_load_top = 1'b1;
                  state_in         = ST_DIGIT;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         ST_DIGIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.sel      = SEL_DIGIT;
               cmd.idx_dec  = 1'b1;
               if (status.digit_last) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_TAIL: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.sel      = SEL_TAIL;
               state_in     = ST_READY;
            end
         end
         default: begin
            state_in = ST_READY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_READY;
         waiting_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         waiting_ff <= waiting_in;
      end
   end

   assign req_stall = state_ff != ST_READY;

endmodule

@@ rtl/ack_timeout_sample_reporter.sv @@
// Stop-and-wait report sender with a retransmit timeout.
// Request channel (req_valid/req_stall/req_data): millisecond ticks and host
// commands. In idle, a reset command latches the sample (kept as before when
// sample_ok is low) and sends "!ADC=<decimal>#"; the block then waits for an
// OK command. While waiting, ticks advance a saturating elapsed count, and when
// it exceeds timeout_ms the same packet goes out again and the count restarts.
// Response channel (rsp_valid/rsp_stall/rsp_data): one transaction per packet
// byte, last_byte set on the closing '#'. csr_wr_en/csr_wr_data write
// timeout_ms; write it only while the block is idle.
// Sequencing: a transaction that sends nothing is accepted without a stall. A
// reset command that starts a packet latches the sample, then runs SAMPLE_BITS
// steps of serial binary to decimal conversion (one bit per cycle), then sends
// 7 to 10 bytes; a resend skips the conversion. req_stall stays high until the last
// byte has moved into the output register. A stalled receiver holds that
// register and pauses the byte sequencer, nothing is dropped.
// Reset: idle mode, elapsed count and held sample zero, timeout 3000 ms.
module ack_timeout_sample_reporter #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  atsr_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output atsr_pkg::rsp_type   rsp_data,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data
);
   import atsr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequence item handling, conversion and the byte stream
   atsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // Hold timeout, elapsed count, sample, BCD digits and the output register
   atsr_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

@@ test/ack_timeout_sample_reporter_checker.sv @@
module ack_timeout_sample_reporter_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  atsr_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  atsr_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   output int                mismatch_count,
   output int                bytes_pending,
   output int                bytes_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import atsr_pkg::*;

   localparam logic [39:0] PACKET_HEAD = "!ADC=";

   logic        waiting_for_ok;
   logic [16:0] elapsed;
   logic [11:0] report_sample;
   logic [15:0] resend_after;
   rsp_type     report_bytes [$];
   int          failures;
   int          checked;

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      failures++;
      $display("%0t ns: report byte %0d: %s got 'h%0h, want 'h%0h",
               $realtime, checked, what, got, want);
   endtask

   // Queue "!ADC=<decimal>#" for the held sample.
   task automatic queue_report();
      logic [7:0]  digit_chars [5];
      logic [11:0] rest;
      rsp_type     b;
      int          n;
      rest = report_sample;
      n = 0;
      do begin
         digit_chars[n] = CHAR_ZERO + 8'(rest % 12'd10);
         rest = rest / 12'd10;
         n++;
      end while (rest != 0);
      b.last_byte = 1'b0;
      for (int i = 0; i < 5; i++) begin
         b.tx_byte = PACKET_HEAD[39 - 8 * i -: 8];
         report_bytes.push_back(b);
      end
      for (int i = n - 1; i >= 0; i--) begin
         b.tx_byte = digit_chars[i];
         report_bytes.push_back(b);
      end
      b.tx_byte = CHAR_HASH;
      b.last_byte = 1'b1;
      report_bytes.push_back(b);
   endtask

   task automatic track_request(input req_type t);
      if (!waiting_for_ok) begin
         if (t.action == ACT_RESET) begin
            if (t.sample_ok)
               report_sample = t.sample;
            elapsed = '0;
            waiting_for_ok = 1'b1;
            queue_report();
         end
      end else if (t.action == ACT_OK) begin
         waiting_for_ok = 1'b0;
      end else begin
         if (t.action == ACT_TICK && elapsed < ELAPSED_MAX)
            elapsed++;
         if (elapsed > {1'b0, resend_after}) begin
            elapsed = '0;
            queue_report();
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         waiting_for_ok = 1'b0;
         elapsed = '0;
         report_sample = '0;
         resend_after = TIMEOUT_RESET;
         report_bytes.delete();
      end else begin
         if (csr_wr_en)
            resend_after = csr_wr_data;
         if (req_valid && !req_stall)
            track_request(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (report_bytes.size() == 0) begin
               report_mismatch("unexpected byte", rsp_data.tx_byte, 8'h00);
            end else begin
               want = report_bytes.pop_front();
               if (rsp_data.tx_byte !== want.tx_byte)
                  report_mismatch("tx_byte", rsp_data.tx_byte, want.tx_byte);
               if (rsp_data.last_byte !== want.last_byte)
                  report_mismatch("last_byte", 8'(rsp_data.last_byte), 8'(want.last_byte));
            end
            checked++;
         end
      end
      mismatch_count <= failures;
      bytes_pending <= report_bytes.size();
      bytes_checked <= checked;
   end

endmodule

@@ test/ack_timeout_sample_reporter_tb.sv @@
module ack_timeout_sample_reporter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import atsr_pkg::*;

   // Action code with no meaning of its own; the block treats it as noise
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Worst packet: sample latch, 12-bit conversion and 10 bytes; leave margin
   localparam int DRAIN_CYCLES    = 40;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_ITEMS     = 63;
   localparam int CYCLE_LIMIT     = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   int mismatch_count;
   int bytes_pending;
   int bytes_checked;

   int send_idle_pct = 15;
   int recv_idle_pct = 73;
   int hold_off_asked = 0;
   int hold_off_served = 0;
   int hold_off_left = 0;
   int items_sent = 0;
   int cycle_count = 0;
   bit offering = 1'b0;

   ack_timeout_sample_reporter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ack_timeout_sample_reporter_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending),
      .bytes_checked  (bytes_checked)
   );

   always #4 clock = ~clock;

   // Receiver side: random stall, or a long hold-off when the stimulus asks for
   // one. The hold-off is counted here so the sender keeps running meanwhile.
   always @(posedge clock) begin
      if (hold_off_left != 0) begin
         rsp_stall <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_served != hold_off_asked) begin
         rsp_stall <= 1'b1;
         hold_off_left <= HOLD_OFF_CYCLES;
         hold_off_served <= hold_off_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d report bytes outstanding",
                  cycle_count, bytes_pending);
         $display("ack_timeout_sample_reporter: mismatch");
         $finish;
      end
   end

   // Offer one request transaction and hold it until accepted. Valid stays high
   // into the next transaction unless a random gap drops it.
   task automatic send_item(input logic [1:0] act, input logic [11:0] smp, input logic ok);
      req_type item;
      item.action = act;
      item.sample = smp;
      item.sample_ok = ok;
      while ($urandom_range(99) < send_idle_pct) begin
         if (offering) begin
            req_valid <= 1'b0;
            offering = 1'b0;
         end
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      offering = 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Stop offering and wait until every predicted byte has arrived, then give
   // the block time to settle.
   task automatic wait_quiet();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      do @(posedge clock); while (bytes_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Return the block to idle, drain, then write the timeout register.
   task automatic retime(input logic [15:0] value);
      send_item(ACT_OK, 12'(value), 1'b1);
      wait_quiet();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One stop-and-wait exchange: report request, a run of ticks with some
   // noise mixed in, and usually an OK. A missing OK leaves the block waiting
   // so the next report request lands as noise.
   task automatic run_exchange(input logic [15:0] timeout_val);
      int ticks;
      int pick;
      if ($urandom_range(9) == 0)
         send_item($urandom_range(1) ? ACT_TICK : ACT_UNUSED, 12'($urandom_range(4095)),
                   1'($urandom_range(1)));
      send_item(ACT_RESET, 12'($urandom_range(4095)), $urandom_range(3) != 0);
      ticks = $urandom_range(2 * timeout_val + 3);
      repeat (ticks) begin
         pick = $urandom_range(99);
         if (pick < 80)
            send_item(ACT_TICK, 12'($urandom_range(4095)), 1'($urandom_range(1)));
         else if (pick < 90)
            send_item(ACT_UNUSED, 12'($urandom_range(4095)), 1'($urandom_range(1)));
         else
            send_item(ACT_RESET, 12'($urandom_range(4095)), 1'($urandom_range(1)));
      end
      if ($urandom_range(9) != 0)
         send_item(ACT_OK, 12'($urandom_range(4095)), 1'($urandom_range(1)));
   endtask

   initial begin
      logic [15:0] phase_timeout;
      int          phase_start;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle noise is dropped, then packets at the reset timeout
      send_item(ACT_TICK, 12'hFFF, 1'b1);
      send_item(ACT_OK, 12'h000, 1'b0);
      send_item(ACT_UNUSED, 12'hABC, 1'b1);
      send_item(ACT_RESET, 12'd0, 1'b1);
      send_item(ACT_TICK, 12'd5, 1'b1);
      send_item(ACT_UNUSED, 12'd5, 1'b0);
      // report request while waiting: sample must not be latched
      send_item(ACT_RESET, 12'd77, 1'b1);
      send_item(ACT_OK, 12'd0, 1'b1);
      send_item(ACT_RESET, 12'd4095, 1'b1);
      send_item(ACT_OK, 12'd0, 1'b0);
      // failed conversion keeps the previous sample
      send_item(ACT_RESET, 12'd1234, 1'b0);
      send_item(ACT_OK, 12'd0, 1'b0);

      // Zero timeout: every tick resends, noise does not
      retime(16'd0);
      send_item(ACT_RESET, 12'd10, 1'b1);
      send_item(ACT_UNUSED, 12'd0, 1'b0);
      send_item(ACT_TICK, 12'd0, 1'b0);
      send_item(ACT_TICK, 12'd0, 1'b0);
      send_item(ACT_OK, 12'd0, 1'b0);

      // Short timeout: resend on the third tick
      retime(16'd2);
      send_item(ACT_RESET, 12'd9, 1'b1);
      repeat (3) send_item(ACT_TICK, 12'd0, 1'b0);
      send_item(ACT_OK, 12'd0, 1'b0);

      // Largest timeout: no resend within reach
      retime(16'hFFFF);
      send_item(ACT_RESET, 12'd2048, 1'b1);
      send_item(ACT_TICK, 12'd0, 1'b1);
      send_item(ACT_OK, 12'd0, 1'b1);

      // Random exchanges in three idling modes
      for (int phase = 0; phase < 3; phase++) begin
         phase_timeout = 16'($urandom_range(5));
         retime(phase_timeout);
         case (phase)
            0: begin
               send_idle_pct = 15;
               recv_idle_pct <= 73;
            end
            1: begin
               send_idle_pct = 73;
               recv_idle_pct <= 15;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
               // long receiver hold-off while the sender keeps going
               hold_off_asked <= hold_off_asked + 1;
            end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS)
            run_exchange(phase_timeout);
      end

      wait_quiet();
      $display("sent %0d request transactions, checked %0d report bytes", items_sent,
               bytes_checked);
      $display("timeouts 0, 2, 3000, 65535 and random small ones; %0d-cycle receiver hold-off",
               HOLD_OFF_CYCLES);
      if (mismatch_count == 0 && bytes_pending == 0) begin
         $display("ack_timeout_sample_reporter: match");
      end else begin
         $display("%0d mismatches, %0d report bytes never arrived", mismatch_count,
                  bytes_pending);
         $display("ack_timeout_sample_reporter: mismatch");
      end
      $finish;
   end

endmodule
